/* rtl/suh_pkg.sv */
package suh_pkg;

	localparam int CHAR_W = 8;
	localparam int SIZE_W = 16;
	localparam int HASH_W = SIZE_W + 1;
	localparam int DVD_W  = 2 * SIZE_W;
	localparam int PROD_W = 2 * HASH_W;

	localparam logic [SIZE_W-1:0]        SEED_MULT    = 16'd31415;
	localparam logic signed [HASH_W-1:0] MULT_STEP    = 17'sd27183;
	localparam logic [SIZE_W-1:0]        RESET_SIZE   = 16'd127;

	// sequencer states for one character
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_H,
		ST_SUM_H,
		ST_DIV_H,
		ST_MUL_A,
		ST_SUM_A,
		ST_DIV_A,
		ST_DONE
	} state_t;

	// remainder unit status
	typedef struct packed {
		logic busy;
		logic done;
	} rem_stat_t;

endpackage

/* rtl/suh_rem.sv */
module suh_rem (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [suh_pkg::DVD_W-1:0]    dividend,
	input  logic [suh_pkg::SIZE_W-1:0]   divisor,
	output suh_pkg::rem_stat_t           stat,
	output logic [suh_pkg::SIZE_W-1:0]   rem
);

	localparam int STEPS = suh_pkg::DVD_W / 2;
	localparam int CNT_W = $clog2(STEPS);
	localparam int RW    = suh_pkg::SIZE_W + 1;

	logic [suh_pkg::DVD_W-1:0]  dvd_q;
	logic [suh_pkg::SIZE_W-1:0] dvs_q;
	logic [suh_pkg::SIZE_W-1:0] rem_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;

	logic [RW-1:0] dvs_ext;
	logic [RW-1:0] t1, r1, t2, r2;

	// two restoring steps per cycle
	always_comb begin
		dvs_ext = {1'b0, dvs_q};
		t1 = {rem_q, dvd_q[suh_pkg::DVD_W-1]};
		r1 = (t1 >= dvs_ext) ? RW'(t1 - dvs_ext) : t1;
		t2 = {r1[suh_pkg::SIZE_W-1:0], dvd_q[suh_pkg::DVD_W-2]};
		r2 = (t2 >= dvs_ext) ? RW'(t2 - dvs_ext) : t2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= CNT_W'(cnt_q + 1'b1);
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[suh_pkg::DVD_W-3:0], 2'b00};
			rem_q <= r2[suh_pkg::SIZE_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign rem       = rem_q;

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("remainder done while still busy");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("remainder started while busy");

endmodule

/* rtl/string_universal_hash.sv */
// channel | direction | handshake          | payload
// --------+-----------+--------------------+---------------------------
// in      | sink      | in_valid, in_stall   | char_byte, last_char
// out     | source    | out_valid, out_stall | bucket_index
// cfg     | sink      | cfg_we               | cfg_wdata (table size M)
//
// one character takes two multiplies on the shared multiplier, two passes through
// the 2-bit-per-cycle remainder unit, and the bookkeeping states
// async reset idles the sequencer, clears the hash, sets the multiplier seed and table size (127)
// in_stall is high from the transfer of a character until its work is done
// a pending result in the output register is held while out_stall is high;
// the next key keeps hashing and only its last character waits for room
module string_universal_hash (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [suh_pkg::CHAR_W-1:0]  char_byte,
	input  logic                               last_char,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [suh_pkg::SIZE_W-1:0]         bucket_index,
	input  logic                               cfg_we,
	input  logic [suh_pkg::SIZE_W-1:0]         cfg_wdata
);

	suh_pkg::state_t state_q, state_d;

	logic [suh_pkg::SIZE_W-1:0]        table_size_q;
	logic signed [suh_pkg::HASH_W-1:0] h_q;
	logic [suh_pkg::SIZE_W-1:0]        a_q;
	logic signed [suh_pkg::CHAR_W-1:0] c_q;
	logic                              last_q;
	logic signed [suh_pkg::PROD_W-1:0] prod_q;
	logic                              neg_q;
	logic                              out_valid_q;
	logic [suh_pkg::SIZE_W-1:0]        bucket_q;

	// shared multiplier operands
	logic signed [suh_pkg::HASH_W-1:0] mul_a, mul_b;
	logic signed [suh_pkg::PROD_W-1:0] c_add, prod_d;
	logic [suh_pkg::PROD_W-1:0]        mag;

	// remainder unit
	suh_pkg::rem_stat_t          div_stat;
	logic                        div_start;
	logic [suh_pkg::SIZE_W-1:0]  div_divisor;
	logic [suh_pkg::SIZE_W-1:0]  div_rem;
	logic [suh_pkg::HASH_W-1:0]  rem_ext;
	logic signed [suh_pkg::HASH_W-1:0] h_new, h_fin;

	logic accept, out_free, load_out;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			suh_pkg::ST_IDLE:  if (accept) state_d = suh_pkg::ST_MUL_H;
			suh_pkg::ST_MUL_H: state_d = suh_pkg::ST_SUM_H;
			suh_pkg::ST_SUM_H: state_d = suh_pkg::ST_DIV_H;
			suh_pkg::ST_DIV_H: if (div_stat.done) state_d = suh_pkg::ST_MUL_A;
			suh_pkg::ST_MUL_A: state_d = suh_pkg::ST_SUM_A;
			suh_pkg::ST_SUM_A: state_d = suh_pkg::ST_DIV_A;
			suh_pkg::ST_DIV_A: if (div_stat.done) state_d = suh_pkg::ST_DONE;
			suh_pkg::ST_DONE:  if (!last_q || out_free) state_d = suh_pkg::ST_IDLE;
			default:           state_d = suh_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall    = 1'b1;
		div_start   = 1'b0;
		div_divisor = table_size_q;
		load_out    = 1'b0;
		case (state_q)
			suh_pkg::ST_IDLE:  in_stall = 1'b0;
			suh_pkg::ST_SUM_H: div_start = 1'b1;
			suh_pkg::ST_SUM_A: begin
				div_start   = 1'b1;
				div_divisor = suh_pkg::SIZE_W'(table_size_q - 1'b1);
			end
			suh_pkg::ST_DONE:  load_out = last_q && out_free;
			default: ;
		endcase
	end

	// one multiplier serves a*h + c and a*27183
	always_comb begin
		mul_a = $signed({1'b0, a_q});
		if (state_q == suh_pkg::ST_MUL_H) begin
			mul_b = h_q;
			c_add = suh_pkg::PROD_W'(c_q);
		end else begin
			mul_b = suh_pkg::MULT_STEP;
			c_add = '0;
		end
		prod_d = mul_a * mul_b + c_add;
	end

	// magnitude for the unsigned remainder, sign reapplied afterwards
	assign mag = prod_q[suh_pkg::PROD_W-1] ? suh_pkg::PROD_W'(-prod_q)
	                                       : suh_pkg::PROD_W'(prod_q);

	suh_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag[suh_pkg::DVD_W-1:0]),
		.divisor  (div_divisor),
		.stat     (div_stat),
		.rem      (div_rem)
	);

	// truncating remainder keeps the dividend's sign
	always_comb begin
		rem_ext = {1'b0, div_rem};
		h_new   = neg_q ? $signed(suh_pkg::HASH_W'(-rem_ext)) : $signed(rem_ext);
		h_fin   = h_q[suh_pkg::HASH_W-1]
		          ? suh_pkg::HASH_W'(h_q + $signed({1'b0, table_size_q}))
		          : h_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= suh_pkg::ST_IDLE;
			table_size_q <= suh_pkg::RESET_SIZE;
			h_q          <= '0;
			a_q          <= suh_pkg::SEED_MULT;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				table_size_q <= cfg_wdata;
			end
			if (state_q == suh_pkg::ST_DIV_H && div_stat.done) begin
				// table size zero forces the hash to zero
				h_q <= (table_size_q == '0) ? '0 : h_new;
			end
			// multiplier only moves when M-1 is nonzero
			if (state_q == suh_pkg::ST_DIV_A && div_stat.done && table_size_q > 16'd1) begin
				a_q <= div_rem;
			end
			if (load_out) begin
				h_q <= '0;
				a_q <= suh_pkg::SEED_MULT;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			c_q    <= char_byte;
			last_q <= last_char;
		end
		if (state_q inside {suh_pkg::ST_MUL_H, suh_pkg::ST_MUL_A}) begin
			prod_q <= prod_d;
		end
		if (state_q inside {suh_pkg::ST_SUM_H, suh_pkg::ST_SUM_A}) begin
			neg_q <= prod_q[suh_pkg::PROD_W-1];
		end
		if (load_out) begin
			bucket_q <= h_fin[suh_pkg::SIZE_W-1:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign bucket_index = bucket_q;

	a_idle_unit_free: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !div_stat.busy)
		else $error("input open while remainder unit busy");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == suh_pkg::ST_DIV_H || state_q == suh_pkg::ST_DIV_A))
		else $error("remainder done outside a divide state");

	a_key_restart: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (h_q == '0 && a_q == suh_pkg::SEED_MULT))
		else $error("hash state not restarted after last character");

	a_bucket_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && table_size_q != '0) |-> (bucket_q < table_size_q))
		else $error("bucket index not below table size");

endmodule
